FILE: design/mfek_pkg.sv
// Package for the Edmonds-Karp max-flow block.
// It holds the command and result payload types, the register indexes and the
// controller/datapath handshake types. No dependencies.
package mfek_pkg;

    localparam int VID_W         = 8;
    localparam int VERTEX_SLOTS  = 256;
    localparam int TOTAL_W       = 27;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 27'h7FF_FFFF;

    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE       = 2'd1;
    localparam logic [1:0] REG_SINK         = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NO_PATH = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  from_vertex;
        logic [7:0]  to_vertex;
        logic [15:0] forward_capacity;
        logic [15:0] reverse_capacity;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [TOTAL_W-1:0]  total_flow;
    } result_t;

    typedef struct packed {
        logic [8:0] vertex_count;
        logic [7:0] source_vertex;
        logic [7:0] sink_vertex;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ADD,
        OP_CLEAR,
        OP_ZERO,
        OP_SRCH_INIT,
        OP_DEQ_RD,
        OP_DEQ_LD,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_SCAN_OD,
        OP_V_SNK,
        OP_PRED_RD,
        OP_EDGE_RD,
        OP_BOTTLE,
        OP_PUSH,
        OP_TOTAL,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD,
        S_CLEAR,
        S_ZERO,
        S_SINIT,
        S_QCHK,
        S_DEQ_RD,
        S_DEQ_LD,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_OD,
        S_SEND,
        S_BN_CHK,
        S_BN_PRED,
        S_BN_EDGE,
        S_BN_CALC,
        S_PU_INIT,
        S_PU_CHK,
        S_PU_PRED,
        S_PU_EDGE,
        S_PU_WR,
        S_TOTAL,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res_status;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic range_bad;
        logic pairs_empty;
        logic zero_last;
        logic queue_empty;
        logic scan_last;
        logic sink_hit;
        logic at_src;
    } dp_stat_t;

endpackage

FILE: design/mfek_ctrl.sv
// Controller state machine for the Edmonds-Karp max-flow block.
// It sequences the datapath through edge loads, searches and augmentations.
// Depends on mfek_pkg.
module mfek_ctrl
    import mfek_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     command,
    input  dp_stat_t stat,
    output ctl_t     ctl,
    output logic     busy
);

    state_t  state_reg, state_next;
    logic    first_reg, first_next;
    status_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b1;
            res_reg   <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next   = STAT_OK;
                    first_next = 1'b1;
                    case (command)
                        CMD_ADD:   state_next = S_ADD;
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_RUN:
                        begin
                            if (stat.range_bad)
                            begin
                                res_next   = STAT_NO_PATH;
                                state_next = S_DONE;
                            end
                            else if (stat.pairs_empty)
                                state_next = S_SINIT;
                            else
                                state_next = S_ZERO;
                        end
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ADD:
            begin
                res_next   = stat.full ? STAT_FULL : STAT_OK;
                state_next = S_DONE;
            end
            S_CLEAR:   state_next = S_DONE;
            S_ZERO:    state_next = stat.zero_last ? S_SINIT : S_ZERO;
            S_SINIT:   state_next = S_QCHK;
            S_QCHK:    state_next = stat.queue_empty ? S_SEND : S_DEQ_RD;
            S_DEQ_RD:  state_next = S_DEQ_LD;
            S_DEQ_LD:  state_next = stat.pairs_empty ? S_QCHK : S_SCAN_RD;
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV: state_next = S_SCAN_OD;
            S_SCAN_OD: state_next = stat.scan_last ? S_QCHK : S_SCAN_RD;
            S_SEND:
            begin
                if (stat.sink_hit)
                    state_next = S_BN_CHK;
                else
                begin
                    res_next   = first_reg ? STAT_NO_PATH : STAT_OK;
                    state_next = S_DONE;
                end
            end
            S_BN_CHK:  state_next = stat.at_src ? S_PU_INIT : S_BN_PRED;
            S_BN_PRED: state_next = S_BN_EDGE;
            S_BN_EDGE: state_next = S_BN_CALC;
            S_BN_CALC: state_next = S_BN_CHK;
            S_PU_INIT: state_next = S_PU_CHK;
            S_PU_CHK:  state_next = stat.at_src ? S_TOTAL : S_PU_PRED;
            S_PU_PRED: state_next = S_PU_EDGE;
            S_PU_EDGE: state_next = S_PU_WR;
            S_PU_WR:   state_next = S_PU_CHK;
            S_TOTAL:
            begin
                first_next = 1'b0;
                state_next = S_SINIT;
            end
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.res_status = res_reg;
        unique case (state_reg)
            S_IDLE:    ctl.op = start ? OP_ACCEPT : OP_NONE;
            S_ADD:     ctl.op = OP_ADD;
            S_CLEAR:   ctl.op = OP_CLEAR;
            S_ZERO:    ctl.op = OP_ZERO;
            S_SINIT:   ctl.op = OP_SRCH_INIT;
            S_DEQ_RD:  ctl.op = OP_DEQ_RD;
            S_DEQ_LD:  ctl.op = OP_DEQ_LD;
            S_SCAN_RD: ctl.op = OP_SCAN_RD;
            S_SCAN_EV: ctl.op = OP_SCAN_EV;
            S_SCAN_OD: ctl.op = OP_SCAN_OD;
            S_SEND:    ctl.op = OP_V_SNK;
            S_PU_INIT: ctl.op = OP_V_SNK;
            S_BN_PRED: ctl.op = OP_PRED_RD;
            S_PU_PRED: ctl.op = OP_PRED_RD;
            S_BN_EDGE: ctl.op = OP_EDGE_RD;
            S_PU_EDGE: ctl.op = OP_EDGE_RD;
            S_BN_CALC: ctl.op = OP_BOTTLE;
            S_PU_WR:   ctl.op = OP_PUSH;
            S_TOTAL:   ctl.op = OP_TOTAL;
            S_DONE:    ctl.op = OP_RESULT;
            default:   ctl.op = OP_NONE;
        endcase
        busy = (state_reg != S_IDLE);
    end

endmodule

FILE: design/mfek_dp.sv
// Datapath of the Edmonds-Karp max-flow block: edge pair, flow, predecessor
// and queue memories, search counters, bottleneck and total arithmetic.
// Depends on mfek_pkg.
module mfek_dp
    import mfek_pkg::*;
#(
    parameter int MAX_VERTICES   = 256,
    parameter int MAX_EDGE_PAIRS = 1024,
    parameter int CAP_BITS       = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  cfg_t     cfg,
    input  ctl_t     ctl,
    output dp_stat_t stat,
    output result_t  result,
    output logic     done
);

    localparam int PW   = (MAX_EDGE_PAIRS > 1) ? $clog2(MAX_EDGE_PAIRS) : 1;
    localparam int CW   = $clog2(MAX_EDGE_PAIRS + 1);
    localparam int EW   = PW + 1;
    localparam int NW   = ($clog2(MAX_VERTICES + 1) > 9) ? $clog2(MAX_VERTICES + 1) : 9;
    localparam int QW   = $clog2(VERTEX_SLOTS);
    localparam int SUMW = ((TOTAL_W > CAP_BITS + 1) ? TOTAL_W : CAP_BITS + 1) + 1;

    typedef struct packed {
        logic [VID_W-1:0]    tail;
        logic [VID_W-1:0]    head;
        logic [CAP_BITS-1:0] cap_fwd;
        logic [CAP_BITS-1:0] cap_rev;
    } pair_t;

    pair_t                     pair_mem [MAX_EDGE_PAIRS];
    logic signed [CAP_BITS:0]  flow_mem [MAX_EDGE_PAIRS];
    logic [EW-1:0]             pred_mem [VERTEX_SLOTS];
    logic [VID_W-1:0]          queue_mem [VERTEX_SLOTS];

    item_t                     item_reg;
    logic [CW-1:0]             count_reg;
    logic [PW-1:0]             zp_reg;
    logic [PW-1:0]             p_reg;
    logic [QW:0]               qh_reg;
    logic [QW:0]               qt_reg;
    logic [VID_W-1:0]          cur_reg;
    logic [VID_W-1:0]          v_reg;
    logic [EW-1:0]             e_reg;
    logic [CAP_BITS:0]         df_reg;
    logic                      df_valid_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic [VERTEX_SLOTS-1:0]   reached_reg;
    pair_t                     pair_q;
    logic signed [CAP_BITS:0]  flow_q;
    logic [EW-1:0]             pred_q;
    logic [VID_W-1:0]          queue_q;
    result_t                   result_reg;
    logic                      done_reg;

    logic [NW-1:0]             n_eff;
    logic                      odd_sel;
    logic [VID_W-1:0]          tail_sel;
    logic [VID_W-1:0]          head_sel;
    logic [CAP_BITS-1:0]       cap_sel;
    logic signed [CAP_BITS:0]  flow_sel;
    logic signed [CAP_BITS+1:0] resid;
    logic [CAP_BITS:0]         resid_u;
    logic                      hit;
    logic [EW-1:0]             e_scan;
    logic [CAP_BITS+1:0]       flow_wide;
    logic [CAP_BITS:0]         flow_new;
    logic [SUMW-1:0]           sum;
    logic [TOTAL_W-1:0]        total_sat;
    logic [PW-1:0]             pair_raddr;
    logic [PW-1:0]             flow_waddr;
    logic                      full;

    always_comb
    begin
        if (cfg.vertex_count < 9'd2)
            n_eff = NW'(2);
        else if (NW'(cfg.vertex_count) > NW'(MAX_VERTICES))
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(cfg.vertex_count);

        full     = (count_reg == CW'(MAX_EDGE_PAIRS));
        odd_sel  = (ctl.op == OP_SCAN_OD) ||
                   (((ctl.op == OP_BOTTLE) || (ctl.op == OP_PUSH)) && e_reg[0]);
        tail_sel = odd_sel ? pair_q.head : pair_q.tail;
        head_sel = odd_sel ? pair_q.tail : pair_q.head;
        cap_sel  = odd_sel ? pair_q.cap_rev : pair_q.cap_fwd;
        flow_sel = odd_sel ? -flow_q : flow_q;
        resid    = $signed({2'b00, cap_sel}) - $signed({flow_sel[CAP_BITS], flow_sel});
        resid_u  = resid[CAP_BITS:0];
        e_scan   = {p_reg, odd_sel};
        hit      = ((ctl.op == OP_SCAN_EV) || (ctl.op == OP_SCAN_OD)) &&
                   (tail_sel == cur_reg) &&
                   (NW'(tail_sel) < n_eff) && (NW'(head_sel) < n_eff) &&
                   !reached_reg[head_sel] && (head_sel != cfg.source_vertex) &&
                   !resid[CAP_BITS+1] && (resid != '0);

        flow_wide = odd_sel ? ({flow_q[CAP_BITS], flow_q} - {1'b0, df_reg})
                            : ({flow_q[CAP_BITS], flow_q} + {1'b0, df_reg});
        flow_new  = flow_wide[CAP_BITS:0];

        sum       = SUMW'(total_reg) + SUMW'(df_reg);
        total_sat = (sum > SUMW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

        pair_raddr = (ctl.op == OP_EDGE_RD) ? pred_q[EW-1:1] : p_reg;
        flow_waddr = (ctl.op == OP_ZERO) ? zp_reg : e_reg[EW-1:1];

        stat.full        = full;
        stat.range_bad   = (NW'(cfg.source_vertex) >= n_eff) ||
                           (NW'(cfg.sink_vertex) >= n_eff);
        stat.pairs_empty = (count_reg == '0);
        stat.zero_last   = (CW'(zp_reg) + CW'(1) == count_reg);
        stat.queue_empty = (qh_reg == qt_reg);
        stat.scan_last   = (CW'(p_reg) + CW'(1) == count_reg);
        stat.sink_hit    = reached_reg[cfg.sink_vertex];
        stat.at_src      = (v_reg == cfg.source_vertex);
    end

    always_ff @(posedge clk)
    begin
        if ((ctl.op == OP_ADD) && !full)
        begin
            pair_mem[count_reg[PW-1:0]] <= '{
                tail:    item_reg.from_vertex,
                head:    item_reg.to_vertex,
                cap_fwd: CAP_BITS'(item_reg.forward_capacity),
                cap_rev: CAP_BITS'(item_reg.reverse_capacity)
            };
        end
        if ((ctl.op == OP_SCAN_RD) || (ctl.op == OP_EDGE_RD))
            pair_q <= pair_mem[pair_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_ZERO)
            flow_mem[flow_waddr] <= '0;
        else if (ctl.op == OP_PUSH)
            flow_mem[flow_waddr] <= $signed(flow_new);
        if ((ctl.op == OP_SCAN_RD) || (ctl.op == OP_EDGE_RD))
            flow_q <= flow_mem[pair_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hit)
            pred_mem[head_sel] <= e_scan;
        if (ctl.op == OP_PRED_RD)
            pred_q <= pred_mem[v_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_SRCH_INIT)
            queue_mem[QW'(0)] <= cfg.source_vertex;
        else if (hit)
            queue_mem[qt_reg[QW-1:0]] <= head_sel;
        if (ctl.op == OP_DEQ_RD)
            queue_q <= queue_mem[qh_reg[QW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_ACCEPT: item_reg <= item;
            OP_DEQ_LD: cur_reg  <= queue_q;
            OP_EDGE_RD: e_reg   <= pred_q;
            OP_RESULT: result_reg <= '{status: ctl.res_status, total_flow: total_reg};
            default: ;
        endcase
        if ((ctl.op == OP_BOTTLE) && (!df_valid_reg || (resid_u < df_reg)))
            df_reg <= resid_u;
        if (ctl.op == OP_V_SNK)
            v_reg <= cfg.sink_vertex;
        else if ((ctl.op == OP_BOTTLE) || (ctl.op == OP_PUSH))
            v_reg <= tail_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            zp_reg       <= '0;
            p_reg        <= '0;
            qh_reg       <= '0;
            qt_reg       <= '0;
            df_valid_reg <= 1'b0;
            total_reg    <= '0;
            reached_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.op == OP_RESULT);
            unique case (ctl.op)
                OP_ACCEPT:
                begin
                    total_reg <= '0;
                    zp_reg    <= '0;
                end
                OP_ADD:
                begin
                    if (!full)
                        count_reg <= count_reg + CW'(1);
                end
                OP_CLEAR:   count_reg <= '0;
                OP_ZERO:    zp_reg <= zp_reg + PW'(1);
                OP_SRCH_INIT:
                begin
                    reached_reg  <= '0;
                    qh_reg       <= '0;
                    qt_reg       <= (QW + 1)'(1);
                    df_valid_reg <= 1'b0;
                end
                OP_DEQ_RD:  qh_reg <= qh_reg + (QW + 1)'(1);
                OP_DEQ_LD:  p_reg <= '0;
                OP_SCAN_OD: p_reg <= p_reg + PW'(1);
                OP_BOTTLE:  df_valid_reg <= 1'b1;
                OP_TOTAL:   total_reg <= total_sat;
                default: ;
            endcase
            if (hit)
            begin
                reached_reg[head_sel] <= 1'b1;
                qt_reg                <= qt_reg + (QW + 1)'(1);
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("Result strobe held for more than one cycle.");
    assert property (@(posedge clk) disable iff (!rst_n) qh_reg <= qt_reg)
        else $error("Search queue read pointer passed the write pointer.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     count_reg <= CW'(MAX_EDGE_PAIRS))
        else $error("Edge pair count exceeds the table size.");
    assert property (@(posedge clk) disable iff (!rst_n)
                     hit |-> (qt_reg <= (QW + 1)'(VERTEX_SLOTS - 1)))
        else $error("Search queue overflow.");
`endif

endmodule

FILE: design/max_flow_edmonds_karp.sv
// Top level of the Edmonds-Karp max-flow block: configuration registers on
// the APB-style port, controller and datapath. Depends on mfek_pkg,
// mfek_ctrl and mfek_dp.
//
// An item transfer happens at a clock edge with start high and busy low.
// Command add stores one edge pair, clear empties the table, run computes the
// maximum flow from source_vertex to sink_vertex over the stored pairs.
// Each item yields exactly one result, shown on result for one cycle with
// done high; the receiver cannot stall it, and a new item may be started
// in that same cycle.
// Add and clear pass through their own state and then S_DONE, the unused
// command goes straight to S_DONE, and done is registered from S_DONE. A
// run with source and sink in range first clears one flow entry per stored
// pair per cycle, then repeats a breadth-first search that scans all stored
// pairs, in read, even and odd steps, for each vertex taken off the queue,
// then walks the found path twice, for the bottleneck and to push the flow.
// Configuration must be written by the user only while busy is low; the
// block itself does not enforce it. Reset empties the edge table and sets
// vertex_count to 256, source to 0 and sink to 255.
module max_flow_edmonds_karp
    import mfek_pkg::*;
#(
    parameter int MAX_VERTICES   = 256,
    parameter int MAX_EDGE_PAIRS = 1024,
    parameter int CAP_BITS       = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t     cfg_reg;
    ctl_t     ctl;
    dp_stat_t stat;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count  <= 9'd256;
            cfg_reg.source_vertex <= 8'd0;
            cfg_reg.sink_vertex   <= 8'd255;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_VERTEX_COUNT: cfg_reg.vertex_count  <= pwdata[8:0];
                REG_SOURCE:       cfg_reg.source_vertex <= pwdata[7:0];
                REG_SINK:         cfg_reg.sink_vertex   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_VERTEX_COUNT: prdata = {23'd0, cfg_reg.vertex_count};
            REG_SOURCE:       prdata = {24'd0, cfg_reg.source_vertex};
            REG_SINK:         prdata = {24'd0, cfg_reg.sink_vertex};
            default:          prdata = '0;
        endcase
    end

    mfek_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    mfek_dp #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_EDGE_PAIRS (MAX_EDGE_PAIRS),
        .CAP_BITS       (CAP_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg_reg),
        .ctl    (ctl),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the max_flow_edmonds_karp block.
// It drives command transfers and APB register writes, and checks every result
// against its own Edmonds-Karp flow calculator. Depends on mfek_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import mfek_pkg::*;

    localparam int PAIRS = 1024;
    localparam int SLOTS = 2 * PAIRS;
    localparam int QUIET_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       item = '0;
    logic        busy;
    logic        done;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    max_flow_edmonds_karp dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #4 clk = ~clk;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      gap_left = 0;
    bit      gaps_on = 1'b1;
    logic    taken = 1'b0;

    logic [8:0]  cfg_vertices = 9'd256;
    logic [7:0]  cfg_source = 8'd0;
    logic [7:0]  cfg_sink = 8'd255;

    logic [7:0]  tail_of[SLOTS];
    logic [7:0]  head_of[SLOTS];
    longint      cap_of[SLOTS];
    longint      flow_of[SLOTS];
    int          pair_count = 0;
    int          adj_first[VERTEX_SLOTS + 1];
    int          adj_edges[SLOTS];
    int          pred_edge[VERTEX_SLOTS];
    bit          seen[VERTEX_SLOTS];
    int          bfs_queue[VERTEX_SLOTS];

    function automatic bit find_path(int src, int snk);
        int qh;
        int qt;
        int cur;
        int e;
        int d;
        qh = 0;
        qt = 0;
        for (int v = 0; v < VERTEX_SLOTS; v++)
            seen[v] = 1'b0;
        bfs_queue[qt++] = src;
        while (qh < qt)
        begin
            cur = bfs_queue[qh++];
            for (int i = adj_first[cur]; i < adj_first[cur + 1]; i++)
            begin
                e = adj_edges[i];
                d = int'(head_of[e]);
                if (!seen[d] && d != src && cap_of[e] > flow_of[e] && qt < VERTEX_SLOTS)
                begin
                    seen[d] = 1'b1;
                    pred_edge[d] = e;
                    bfs_queue[qt++] = d;
                end
            end
        end
        return seen[snk];
    endfunction

    function automatic result_t compute_flow();
        result_t r;
        int n;
        int src;
        int snk;
        int fill[VERTEX_SLOTS];
        int v;
        int steps;
        int e;
        longint df;
        longint total;
        bit first;
        r = '{status: STAT_OK, total_flow: '0};
        n = int'(cfg_vertices);
        if (n < 2) n = 2;
        if (n > VERTEX_SLOTS) n = VERTEX_SLOTS;
        src = int'(cfg_source);
        snk = int'(cfg_sink);
        for (int i = 0; i < SLOTS; i++)
            flow_of[i] = 0;
        if (src >= n || snk >= n)
        begin
            r.status = STAT_NO_PATH;
            return r;
        end
        for (int i = 0; i <= VERTEX_SLOTS; i++)
            adj_first[i] = 0;
        for (int i = 0; i < 2 * pair_count; i++)
            if (tail_of[i] < n && head_of[i] < n)
                adj_first[tail_of[i] + 1]++;
        for (int i = 0; i < n; i++)
            adj_first[i + 1] += adj_first[i];
        for (int i = 0; i < n; i++)
            fill[i] = adj_first[i];
        for (int i = 0; i < 2 * pair_count; i++)
            if (tail_of[i] < n && head_of[i] < n)
                adj_edges[fill[tail_of[i]]++] = i;
        total = 0;
        first = 1'b1;
        forever
        begin
            if (!find_path(src, snk))
            begin
                if (first)
                begin
                    r.status = STAT_NO_PATH;
                    return r;
                end
                break;
            end
            first = 1'b0;
            df = -1;
            v = snk;
            for (steps = 0; v != src && steps < n; steps++)
            begin
                e = pred_edge[v];
                if (df < 0 || cap_of[e] - flow_of[e] < df) df = cap_of[e] - flow_of[e];
                v = int'(tail_of[e]);
            end
            v = snk;
            for (steps = 0; v != src && steps < n; steps++)
            begin
                e = pred_edge[v];
                flow_of[e] += df;
                flow_of[e ^ 1] -= df;
                v = int'(tail_of[e]);
            end
            total += df;
            if (total > longint'(TOTAL_MAX)) total = longint'(TOTAL_MAX);
        end
        r.total_flow = total[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic result_t apply_command(item_t it);
        result_t r;
        r = '{status: STAT_OK, total_flow: '0};
        case (it.command)
            CMD_ADD:
            begin
                if (pair_count >= PAIRS)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    tail_of[2 * pair_count] = it.from_vertex;
                    head_of[2 * pair_count] = it.to_vertex;
                    cap_of[2 * pair_count] = longint'(it.forward_capacity);
                    tail_of[2 * pair_count + 1] = it.to_vertex;
                    head_of[2 * pair_count + 1] = it.from_vertex;
                    cap_of[2 * pair_count + 1] = longint'(it.reverse_capacity);
                    pair_count++;
                end
            end
            CMD_CLEAR: pair_count = 0;
            CMD_RUN: r = compute_flow();
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d flow %0d",
                                 result.status, result.total_flow);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== result.status ||
                        want.total_flow !== result.total_flow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected status %0d flow %0d, got %0d %0d",
                                     want.status, want.total_flow, result.status,
                                     result.total_flow);
                    end
                end
            end
            taken <= start && !busy;
            if (start && !busy)
                expected_results.push_back(apply_command(item));
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        logic next_start;
        next_start = start;
        if (start && taken)
            next_start = 1'b0;
        if (rst_n && !next_start)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                next_start = 1'b1;
                gap_left <= gaps_on ? int'($urandom_range(0, 4)) : 0;
            end
        end
        start <= next_start;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_VERTEX_COUNT: cfg_vertices = value[8:0];
            REG_SOURCE: cfg_source = value[7:0];
            default: cfg_sink = value[7:0];
        endcase
    endtask

    task automatic configure(int vertices, int src, int snk);
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_VERTEX_COUNT, 32'(vertices));
        write_reg(REG_SOURCE, 32'(src));
        write_reg(REG_SINK, 32'(snk));
    endtask

    function automatic void queue_cmd(cmd_t c, int a = 0, int b = 0, int fc = 0, int rc = 0);
        item_t it;
        it.command = c;
        it.from_vertex = 8'(a);
        it.to_vertex = 8'(b);
        it.forward_capacity = 16'(fc);
        it.reverse_capacity = 16'(rc);
        pending_items.push_back(it);
    endfunction

    function automatic int pick_capacity();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return int'($urandom_range(0, 15));
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int n;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(CMD_RUN);
        queue_cmd(CMD_ADD, 0, 255, 16'hFFFF, 0);
        queue_cmd(CMD_ADD, 0, 255, 0, 16'hFFFF);
        queue_cmd(CMD_ADD, 255, 0, 16'hFFFF, 16'hFFFF);
        queue_cmd(CMD_RUN);
        queue_cmd(CMD_NONE, 255, 255, 16'hFFFF, 16'hFFFF);
        queue_cmd(CMD_ADD, 0, 128, 300, 7);
        queue_cmd(CMD_ADD, 128, 255, 200, 0);
        queue_cmd(CMD_RUN);
        queue_cmd(CMD_CLEAR);
        queue_cmd(CMD_RUN);
        configure(256, 5, 5);
        queue_cmd(CMD_ADD, 5, 6, 9, 9);
        queue_cmd(CMD_RUN);
        configure(0, 0, 1);
        queue_cmd(CMD_CLEAR);
        queue_cmd(CMD_ADD, 0, 1, 40, 3);
        queue_cmd(CMD_ADD, 0, 200, 50, 50);
        queue_cmd(CMD_ADD, 1, 0, 11, 0);
        queue_cmd(CMD_RUN);
        configure(511, 254, 1);
        queue_cmd(CMD_RUN);
        configure(100, 200, 1);
        queue_cmd(CMD_RUN);

        configure(4, 10, 1);
        queue_cmd(CMD_CLEAR);
        for (int i = 0; i < PAIRS; i++)
            queue_cmd(CMD_ADD, $urandom_range(0, 3), $urandom_range(0, 3),
                      pick_capacity(), pick_capacity());
        queue_cmd(CMD_ADD, 1, 2, 3, 4);
        queue_cmd(CMD_RUN);
        queue_cmd(CMD_CLEAR);

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: n = $urandom_range(2, 12);
                1: n = 256;
                2: n = $urandom_range(0, 1);
                default: n = $urandom_range(3, 40);
            endcase
            if (n < 2)
                configure(n, $urandom_range(0, 1), $urandom_range(0, 1));
            else if ($urandom_range(0, 7) == 0)
                configure(n, $urandom_range(0, 255), $urandom_range(0, 255));
            else
                configure(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
            if (n < 2) n = 2;
            if (n > 256) n = 256;
            gaps_on = (phase % 3) != 2;
            for (int s = 0; s < 5; s++)
            begin
                if ($urandom_range(0, 9) != 0)
                    queue_cmd(CMD_CLEAR);
                k = $urandom_range(1, 12);
                for (int j = 0; j < k; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_cmd(CMD_ADD, $urandom_range(0, 255), $urandom_range(0, 255),
                                  pick_capacity(), pick_capacity());
                    else if (n == 256 && $urandom_range(0, 1))
                        queue_cmd(CMD_ADD,
                                  (j == 0) ? int'(cfg_source) : $urandom_range(0, 255),
                                  (j == k - 1) ? int'(cfg_sink) : $urandom_range(0, 255),
                                  pick_capacity(), pick_capacity());
                    else
                        queue_cmd(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  pick_capacity(), pick_capacity());
                end
                if ($urandom_range(0, 4) == 0)
                    queue_cmd(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                queue_cmd(CMD_RUN);
                if ($urandom_range(0, 3) == 0)
                    queue_cmd(CMD_RUN);
            end
        end

        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: max_flow_edmonds_karp.f
design/mfek_pkg.sv
design/mfek_ctrl.sv
design/mfek_dp.sv
design/max_flow_edmonds_karp.sv
dv/tb_top.sv
